// ===== rtl/balance_cascade_controller_defines.svh =====
// ---------------------------------------------------------------------------
// Balance cascade controller assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef BALANCE_CASCADE_CONTROLLER_DEFINES_SVH
`define BALANCE_CASCADE_CONTROLLER_DEFINES_SVH

// same-cycle implication, off during reset
`define BCC_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bcc port check failed");

// next-cycle implication, off during reset
`define BCC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bcc port check failed");

// what the ports show in the cycle after a reset cycle
`define BCC_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("bcc reset check failed");

`endif

// ===== rtl/bcc_pkg.sv =====
// ---------------------------------------------------------------------------
// Balance cascade controller package
// Word types, register indexes and fixed constants shared by the block.
// ---------------------------------------------------------------------------
package bcc_pkg;

   // fixed field widths
   localparam int ANGLE_W = 17;
   localparam int RATE_W  = 16;
   localparam int WHEEL_W = 16;
   localparam int SUM_W   = 17;
   localparam int FILT_W  = 18;
   localparam int INTEG_W = 15;
   localparam int NUM_W   = 22;   // 3*sum + 7*filtered
   localparam int MAG_W   = 21;
   localparam int GAIN_W  = 32;
   localparam int PROD_W  = 64;
   localparam int TURN_W  = 16;
   localparam int CSR_IDX_W = 2;

   // divide by 10: ceil(2^28 / 10), exact for magnitudes below 2^26
   localparam logic signed [GAIN_W-1:0] DIV10_MULT  = 32'sd26843546;
   localparam int                       DIV10_SHIFT = 28;

   // register reset values
   localparam logic signed [GAIN_W-1:0] TILT_GAIN_RESET      = -32'sd13107200;
   localparam logic signed [GAIN_W-1:0] TILT_RATE_GAIN_RESET = -32'sd13107;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILT_GAIN           = 2'd0,
      CSR_TILT_RATE_GAIN      = 2'd1,
      CSR_SPEED_GAIN          = 2'd2,
      CSR_SPEED_INTEGRAL_GAIN = 2'd3
   } csr_index_type;

   // post-scale selection
   typedef enum logic {
      SCALE_BALANCE = 1'b0,   // by 2^(frac+8)
      SCALE_GAIN    = 1'b1    // by 2^frac
   } scale_sel_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] tilt_angle;
      logic signed [RATE_W-1:0]  tilt_rate;
      logic signed [WHEEL_W-1:0] wheel_speed_a;
      logic signed [WHEEL_W-1:0] wheel_speed_b;
      logic signed [RATE_W-1:0]  yaw_rate;
   } req_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] drive_value;
      logic signed [GAIN_W-1:0] balance_term;
      logic signed [GAIN_W-1:0] speed_term;
      logic signed [TURN_W-1:0] turn_term;
   } rsp_type;

   // operand pair for the shared multiplier
   typedef struct packed {
      logic signed [GAIN_W-1:0] op_a;
      logic signed [GAIN_W-1:0] op_b;
   } mul_op_type;

endpackage

// ===== rtl/bcc_mul.sv =====
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 32 x 32 multiply with a registered 64-bit product.
// ---------------------------------------------------------------------------
module bcc_mul (
   input  logic                                     clock,
   input  bcc_pkg::mul_op_type                      mul_op,
   output logic signed [bcc_pkg::PROD_W-1:0]        product
);

   logic signed [bcc_pkg::PROD_W-1:0] product_ff;
   logic signed [bcc_pkg::PROD_W-1:0] product_in;

   // full-width signed product
   assign product_in = bcc_pkg::PROD_W'(mul_op.op_a) * bcc_pkg::PROD_W'(mul_op.op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/bcc_scale.sv =====
// ---------------------------------------------------------------------------
// Term scaler
// Divides an accumulator by a power of two toward zero and saturates to 32 bits.
// ---------------------------------------------------------------------------
module bcc_scale #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic signed [bcc_pkg::PROD_W-1:0]  value,
   input  bcc_pkg::scale_sel_type             sel,
   output logic signed [bcc_pkg::GAIN_W-1:0]  result
);

   localparam int K_BAL  = GAIN_FRAC_BITS + 8;
   localparam int K_GAIN = GAIN_FRAC_BITS;
   localparam logic signed [bcc_pkg::PROD_W-1:0] BIAS_BAL  = (64'sd1 <<< K_BAL) - 64'sd1;
   localparam logic signed [bcc_pkg::PROD_W-1:0] BIAS_GAIN = (64'sd1 <<< K_GAIN) - 64'sd1;
   localparam logic signed [bcc_pkg::PROD_W-1:0] SAT_MAX   = 64'sd2147483647;
   localparam logic signed [bcc_pkg::PROD_W-1:0] SAT_MIN   = -64'sd2147483648;

   logic signed [bcc_pkg::PROD_W-1:0] biased;
   logic signed [bcc_pkg::PROD_W-1:0] shifted;

   // negative values get a bias so the shift truncates toward zero
   always_comb begin
      biased  = value;
      shifted = '0;
      case (sel)
         bcc_pkg::SCALE_BALANCE: begin
            if (value < 0) biased = value + BIAS_BAL;
            shifted = biased >>> K_BAL;
         end
         bcc_pkg::SCALE_GAIN: begin
            if (value < 0) biased = value + BIAS_GAIN;
            shifted = biased >>> K_GAIN;
         end
         default: begin
            shifted = '0;
         end
      endcase
   end

   // saturate to the signed 32-bit range
   always_comb begin
      if (shifted > SAT_MAX) begin
         result = SAT_MAX[bcc_pkg::GAIN_W-1:0];
      end else if (shifted < SAT_MIN) begin
         result = SAT_MIN[bcc_pkg::GAIN_W-1:0];
      end else begin
         result = shifted[bcc_pkg::GAIN_W-1:0];
      end
   end

endmodule

// ===== rtl/balance_cascade_controller.sv =====
// ---------------------------------------------------------------------------
// Balance cascade controller
// Upright PD and speed PI cascade for a two-wheeled balancing platform.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one sensor sample word (tilt angle, tilt rate, two wheel speeds,
//            yaw rate) under valid/ready.
//   rsp_*  : one result word per sample (drive, balance, speed and turn
//            terms) under valid/ready, held in an output register.
//   csr_*  : gain writes, taken at any edge with csr_write_enable high;
//            write them only while no sample is in flight.
// Timing: a sample is taken when req_ready is high (sequencer idle). It then
//   runs through the BAL, INTEG, SPD and DRV steps on one shared 32x32
//   multiplier: five products plus a reciprocal multiply for the divide by
//   ten of the speed filter. No new sample is taken while one is in flight;
//   the next one can be taken as soon as the result shows on rsp_valid.
// Stall: a result waiting on rsp_ready does not block the next sample; the
//   sequencer only waits in its last step if the output register is still full.
// Reset: gains return to their defaults, filter and integral clear, the
//   output register empties and the sequencer goes idle.
// ---------------------------------------------------------------------------
module balance_cascade_controller #(
   parameter int INTEGRAL_LIMIT = 10000,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bcc_pkg::req_type                    req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bcc_pkg::rsp_type                    rsp_data,
   // gain registers
   input  logic                                csr_write_enable,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bcc_pkg::GAIN_W-1:0]          csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BAL_A,
      ST_BAL_B,
      ST_BAL_C,
      ST_BAL_D,
      ST_INTEG,
      ST_SPD_A,
      ST_SPD_B,
      ST_SPD_C,
      ST_SPD_D,
      ST_DRV_A,
      ST_DRV_B,
      ST_DRV_C
   } state_type;

   localparam int IW = bcc_pkg::INTEG_W + 4;   // integral sum width
   localparam logic signed [IW-1:0] LIMIT_POS = IW'(INTEGRAL_LIMIT);
   localparam logic signed [IW-1:0] LIMIT_NEG = -IW'(INTEGRAL_LIMIT);

   // control and state registers
   state_type                               state_ff, state_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   bcc_pkg::rsp_type                        rsp_data_ff, rsp_data_in;
   logic signed [bcc_pkg::GAIN_W-1:0]       tilt_gain_ff, tilt_gain_in;
   logic signed [bcc_pkg::GAIN_W-1:0]       tilt_rate_gain_ff, tilt_rate_gain_in;
   logic signed [bcc_pkg::GAIN_W-1:0]       speed_gain_ff, speed_gain_in;
   logic signed [bcc_pkg::GAIN_W-1:0]       speed_integral_gain_ff, speed_integral_gain_in;
   logic signed [bcc_pkg::FILT_W-1:0]       filt_ff, filt_in;
   logic signed [bcc_pkg::INTEG_W-1:0]      integ_ff, integ_in;

   // datapath registers
   bcc_pkg::req_type                        sample_ff, sample_in;
   logic signed [bcc_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [bcc_pkg::MAG_W-1:0]               mag_ff, mag_in;
   logic                                    num_neg_ff, num_neg_in;
   logic signed [bcc_pkg::TURN_W-1:0]       turn_ff, turn_in;
   logic signed [bcc_pkg::PROD_W-1:0]       acc_ff, acc_in;
   logic signed [bcc_pkg::GAIN_W-1:0]       bal_ff, bal_in;
   logic signed [bcc_pkg::GAIN_W-1:0]       spd_ff, spd_in;

   // shared units
   bcc_pkg::mul_op_type                     mul_op;
   logic signed [bcc_pkg::PROD_W-1:0]       product;
   bcc_pkg::scale_sel_type                  scale_sel;
   logic signed [bcc_pkg::GAIN_W-1:0]       scaled;

   // helpers
   logic                                    req_fire;
   logic                                    out_free;
   logic signed [bcc_pkg::NUM_W-1:0]        sum_x;
   logic signed [bcc_pkg::NUM_W-1:0]        filt_x;
   logic signed [bcc_pkg::NUM_W-1:0]        num;
   logic signed [bcc_pkg::ANGLE_W-1:0]      neg_yaw;
   logic signed [bcc_pkg::ANGLE_W-1:0]      half_yaw;
   logic [bcc_pkg::FILT_W-1:0]              quot;
   logic signed [IW-1:0]                    integ_sum;

   bcc_mul u_mul (
      .clock   (clock),
      .mul_op  (mul_op),
      .product (product)
   );

   bcc_scale #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_scale (
      .value  (acc_ff),
      .sel    (scale_sel),
      .result (scaled)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // filter numerator 3*sum + 7*filtered, formed from the incoming sample
   always_comb begin
      sum_in = bcc_pkg::SUM_W'(req_data.wheel_speed_a)
             + bcc_pkg::SUM_W'(req_data.wheel_speed_b);
      sum_x  = bcc_pkg::NUM_W'(sum_in);
      filt_x = bcc_pkg::NUM_W'(filt_ff);
      num    = (sum_x <<< 1) + sum_x + (filt_x <<< 3) - filt_x;
      num_neg_in = num[bcc_pkg::NUM_W-1];
      mag_in = num_neg_in ? bcc_pkg::MAG_W'(-num) : bcc_pkg::MAG_W'(num);
   end

   // turn term: -yaw / 2 toward zero
   always_comb begin
      neg_yaw  = -bcc_pkg::ANGLE_W'(req_data.yaw_rate);
      half_yaw = (neg_yaw + bcc_pkg::ANGLE_W'(neg_yaw[bcc_pkg::ANGLE_W-1])) >>> 1;
      turn_in  = half_yaw[bcc_pkg::TURN_W-1:0];
   end

   // quotient of the filter divide and the integral sum before it is clamped
   always_comb begin
      quot      = product[bcc_pkg::DIV10_SHIFT +: bcc_pkg::FILT_W];
      integ_sum = IW'(integ_ff) + IW'(filt_ff);
   end

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      filt_in       = filt_ff;
      integ_in      = integ_ff;
      sample_in     = sample_ff;
      acc_in        = acc_ff;
      bal_in        = bal_ff;
      spd_in        = spd_ff;
      mul_op.op_a   = '0;
      mul_op.op_b   = '0;
      scale_sel     = bcc_pkg::SCALE_GAIN;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = req_data;
               state_in  = ST_BAL_A;
            end
         end
         ST_BAL_A: begin
            mul_op.op_a = tilt_gain_ff;
            mul_op.op_b = bcc_pkg::GAIN_W'(sample_ff.tilt_angle);
            state_in    = ST_BAL_B;
         end
         ST_BAL_B: begin
            mul_op.op_a = tilt_rate_gain_ff;
            mul_op.op_b = bcc_pkg::GAIN_W'(sample_ff.tilt_rate);
            acc_in      = product;
            state_in    = ST_BAL_C;
         end
         ST_BAL_C: begin
            mul_op.op_a = bcc_pkg::DIV10_MULT;
            mul_op.op_b = bcc_pkg::GAIN_W'(mag_ff);
            acc_in      = acc_ff + (product <<< 8);
            state_in    = ST_BAL_D;
         end
         ST_BAL_D: begin
            scale_sel = bcc_pkg::SCALE_BALANCE;
            bal_in    = scaled;
            filt_in   = num_neg_ff ? -$signed(quot) : $signed(quot);
            state_in  = ST_INTEG;
         end
         ST_INTEG: begin
            if (integ_sum > LIMIT_POS) begin
               integ_in = LIMIT_POS[bcc_pkg::INTEG_W-1:0];
            end else if (integ_sum < LIMIT_NEG) begin
               integ_in = LIMIT_NEG[bcc_pkg::INTEG_W-1:0];
            end else begin
               integ_in = integ_sum[bcc_pkg::INTEG_W-1:0];
            end
            state_in = ST_SPD_A;
         end
         ST_SPD_A: begin
            mul_op.op_a = speed_gain_ff;
            mul_op.op_b = bcc_pkg::GAIN_W'(sum_ff);
            state_in    = ST_SPD_B;
         end
         ST_SPD_B: begin
            mul_op.op_a = speed_integral_gain_ff;
            mul_op.op_b = bcc_pkg::GAIN_W'(integ_ff);
            acc_in      = product;
            state_in    = ST_SPD_C;
         end
         ST_SPD_C: begin
            acc_in   = acc_ff + product;
            state_in = ST_SPD_D;
         end
         ST_SPD_D: begin
            spd_in   = scaled;
            state_in = ST_DRV_A;
         end
         ST_DRV_A: begin
            mul_op.op_a = tilt_gain_ff;
            mul_op.op_b = spd_ff;
            state_in    = ST_DRV_B;
         end
         ST_DRV_B: begin
            acc_in   = (bcc_pkg::PROD_W'(bal_ff) <<< GAIN_FRAC_BITS) - product;
            state_in = ST_DRV_C;
         end
         ST_DRV_C: begin
            // wait here until the output register has room
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.drive_value  = scaled;
               rsp_data_in.balance_term = bal_ff;
               rsp_data_in.speed_term   = spd_ff;
               rsp_data_in.turn_term    = turn_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // gain register writes
   always_comb begin
      tilt_gain_in           = tilt_gain_ff;
      tilt_rate_gain_in      = tilt_rate_gain_ff;
      speed_gain_in          = speed_gain_ff;
      speed_integral_gain_in = speed_integral_gain_ff;
      if (csr_write_enable) begin
         case (bcc_pkg::csr_index_type'(csr_index))
            bcc_pkg::CSR_TILT_GAIN:           tilt_gain_in           = csr_write_data;
            bcc_pkg::CSR_TILT_RATE_GAIN:      tilt_rate_gain_in      = csr_write_data;
            bcc_pkg::CSR_SPEED_GAIN:          speed_gain_in          = csr_write_data;
            bcc_pkg::CSR_SPEED_INTEGRAL_GAIN: speed_integral_gain_in = csr_write_data;
            default: begin
               tilt_gain_in = tilt_gain_ff;
            end
         endcase
      end
   end

   // state, registered outputs and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff               <= ST_IDLE;
         rsp_valid_ff           <= 1'b0;
         tilt_gain_ff           <= bcc_pkg::TILT_GAIN_RESET;
         tilt_rate_gain_ff      <= bcc_pkg::TILT_RATE_GAIN_RESET;
         speed_gain_ff          <= '0;
         speed_integral_gain_ff <= '0;
         filt_ff                <= '0;
         integ_ff               <= '0;
      end else begin
         state_ff               <= state_in;
         rsp_valid_ff           <= rsp_valid_in;
         rsp_data_ff            <= rsp_data_in;
         tilt_gain_ff           <= tilt_gain_in;
         tilt_rate_gain_ff      <= tilt_rate_gain_in;
         speed_gain_ff          <= speed_gain_in;
         speed_integral_gain_ff <= speed_integral_gain_in;
         filt_ff                <= filt_in;
         integ_ff               <= integ_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      acc_ff    <= acc_in;
      bal_ff    <= bal_in;
      spd_ff    <= spd_in;
      if (req_fire) begin
         sum_ff     <= sum_in;
         mag_ff     <= mag_in;
         num_neg_ff <= num_neg_in;
         turn_ff    <= turn_in;
      end
   end

endmodule

// ===== rtl/bcc_checker.sv =====
// ---------------------------------------------------------------------------
// Balance cascade controller port checker
// Watches the top-level handshakes over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "balance_cascade_controller_defines.svh"

module bcc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bcc_pkg::rsp_type rsp_data
);

   // a stalled result word stays put
   `BCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // the sequencer is busy right after taking a sample
   `BCC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // a new result only comes out of a busy period
   `BCC_ASSERT_HOLDS(a_rsp_after_work, $rose(rsp_valid), !$past(req_ready))

   // reset leaves the block idle with an empty output
   `BCC_ASSERT_AFTER_RESET(a_reset_idle, !rsp_valid && req_ready)

endmodule

bind balance_cascade_controller bcc_checker u_bcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
